// ===== sv/double_ended_queue_top_assert.svh =====
// assertion macros for the deque top level
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// checked on every edge outside reset
`define DEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DEQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/deq_pkg.sv =====
`default_nettype none

package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 3;
    localparam int ST_W    = 2;
    localparam int IN_RAW  = OP_W + WORD_W;
    localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
    localparam int OUT_RAW = 2 * WORD_W + CNT_W + 1 + ST_W;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_NONE       = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH_FRONT,
        CMD_PUSH_BACK,
        CMD_POP_FRONT,
        CMD_POP_BACK
    } cell_cmd_t;

    typedef struct packed {
        logic  valid;
        word_t data;
    } cell_link_t;

    typedef struct packed {
        cell_cmd_t cmd;
        word_t     push_value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/double_ended_queue_top.sv =====
// deque of signed words held in a row of cells, front at cell zero
// latency: a result is offered the cycle after its item is accepted
// throughput: one item per cycle unless stalled; cells update that cycle
// an output waiting on m_tready holds s_tready low only when not taken
// reset (rst_n, async, active low) empties the queue and drops m_tvalid
`default_nettype none
`include "double_ended_queue_top_assert.svh"

module double_ended_queue_top
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // op, push_value, zero pad
    input  wire logic [deq_pkg::IN_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // front_value, back_value, occupancy, is_empty, status
    output logic [deq_pkg::OUT_W-1:0]    m_tdata
);
    import deq_pkg::*;

    op_t        op;
    word_t      push_value;
    logic       in_fire;
    logic       full;
    logic       empty;
    cell_ctrl_t ctrl;
    cell_cmd_t  cmd;
    cnt_t       count_reg;
    cnt_t       count_next;
    status_t    status_reg;
    status_t    status_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    cell_link_t links [DEPTH];
    word_t      tails [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    word_t      front_value;
    word_t      back_value;

    assign op         = op_t'(s_tdata[OP_W-1:0]);
    assign push_value = s_tdata[OP_W +: WORD_W];
    assign s_tready   = !out_valid_reg || m_tready;
    assign in_fire    = s_tvalid && s_tready;
    assign full       = cell_valid[DEPTH-1];
    assign empty      = !cell_valid[0];

    always_comb
    begin
        cmd         = CMD_HOLD;
        status_next = status_reg;
        count_next  = count_reg;
        if (in_fire)
        begin
            status_next = ST_OK;
            unique case (op) inside
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = ST_PUSH_FULL;
                    end
                    else
                    begin
                        cmd        = (op == OP_PUSH_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                        count_next = count_reg + cnt_t'(1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = ST_POP_EMPTY;
                    end
                    else
                    begin
                        cmd        = (op == OP_POP_FRONT) ? CMD_POP_FRONT : CMD_POP_BACK;
                        count_next = count_reg - cnt_t'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign ctrl.cmd        = cmd;
    assign ctrl.push_value = push_value;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_link_t left_link;
            cell_link_t right_link;

            if (i == 0)
            begin : g_first
                assign left_link.valid = 1'b1;
                assign left_link.data  = push_value;
            end
            else
            begin : g_mid_left
                assign left_link = links[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_link.valid = 1'b0;
                assign right_link.data  = '0;
            end
            else
            begin : g_mid_right
                assign right_link = links[i+1];
            end

            deq_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_link  (left_link),
                .right_link (right_link),
                .link       (links[i]),
                .tail_word  (tails[i])
            );

            assign cell_valid[i] = links[i].valid;
        end
    endgenerate

    // exactly one cell is the tail when not empty
    always_comb
    begin
        back_value = '0;
        for (int k = 0; k < DEPTH; k++)
        begin
            back_value = back_value | tails[k];
        end
        if (empty)
        begin
            back_value = '1;
        end
    end

    assign front_value = empty ? '1 : links[0].data;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({status_reg, empty, count_reg, back_value, front_value});

    `DEQ_ASSERT_ALWAYS(a_count_matches_cells, $countones(cell_valid) == int'(count_reg), "count differs from filled cells")
    `DEQ_ASSERT(a_count_bounded, int'(count_reg) <= DEPTH, "count above depth")
    `DEQ_ASSERT(a_reject_holds, (in_fire && cmd == CMD_HOLD) |=> $stable(cell_valid), "ignored item changed the cells")
    `DEQ_ASSERT(a_held_result, (m_tvalid && !m_tready) |=> $stable(count_reg) && $stable(status_reg), "state moved under a stalled result")

endmodule

`default_nettype wire

// ===== sv/deq_cell.sv =====
`default_nettype none

module deq_cell
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire deq_pkg::cell_ctrl_t    ctrl,
    input  wire deq_pkg::cell_link_t    left_link,
    input  wire deq_pkg::cell_link_t    right_link,
    output deq_pkg::cell_link_t         link,
    output deq_pkg::word_t              tail_word
);
    import deq_pkg::*;

    word_t data_reg;
    word_t data_next;
    logic  valid_reg;
    logic  valid_next;
    logic  is_tail;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        unique case (ctrl.cmd)
            CMD_PUSH_FRONT:
            begin
                data_next  = left_link.data;
                valid_next = left_link.valid;
            end
            CMD_PUSH_BACK:
            begin
                // first free cell takes the word
                if (left_link.valid && !valid_reg)
                begin
                    data_next  = ctrl.push_value;
                    valid_next = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                data_next  = right_link.data;
                valid_next = right_link.valid;
            end
            CMD_POP_BACK:
            begin
                if (valid_reg && !right_link.valid)
                begin
                    valid_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign is_tail    = valid_reg && !right_link.valid;
    assign link.valid = valid_reg;
    assign link.data  = data_reg;
    assign tail_word  = is_tail ? data_reg : '0;

endmodule

`default_nettype wire
